>>> design/mbrtu_pkg.sv
`timescale 1ns / 1ps

package mbrtu_pkg;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned ADDR_W      = 16;
   localparam int unsigned COUNT_W     = 16;
   localparam int unsigned STATUS_W    = 4;
   localparam int unsigned CRC_W       = 16;
   localparam int unsigned STEP_W      = 3;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 16;

   // item kinds on the request channel
   localparam logic OP_HEADER = 1'b0;
   localparam logic OP_DATA   = 1'b1;

   // supported function codes
   localparam logic [BYTE_W-1:0] FC_READ_COILS  = 8'h01;
   localparam logic [BYTE_W-1:0] FC_READ_REGS   = 8'h03;
   localparam logic [BYTE_W-1:0] FC_WRITE_COILS = 8'h0F;
   localparam logic [BYTE_W-1:0] FC_WRITE_REGS  = 8'h10;

   // crc-16/modbus, reflected form
   localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
   localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

   // register defaults
   localparam logic [BYTE_W-1:0]  SLAVE_MIN_RST        = 8'd1;
   localparam logic [BYTE_W-1:0]  SLAVE_MAX_RST        = 8'd247;
   localparam logic [ADDR_W-1:0]  ADDR_LOWEST_RST      = 16'd0;
   localparam logic [ADDR_W-1:0]  ADDR_HIGHEST_RST     = 16'd65535;
   localparam logic [COUNT_W-1:0] READ_COIL_LIMIT_RST  = 16'd2000;
   localparam logic [COUNT_W-1:0] READ_REG_LIMIT_RST   = 16'd125;
   localparam logic [COUNT_W-1:0] WRITE_COIL_LIMIT_RST = 16'd1968;
   localparam logic [COUNT_W-1:0] WRITE_REG_LIMIT_RST  = 16'd123;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SLAVE_MIN        = 3'd0,
      CSR_SLAVE_MAX        = 3'd1,
      CSR_ADDR_LOWEST      = 3'd2,
      CSR_ADDR_HIGHEST     = 3'd3,
      CSR_READ_COIL_LIMIT  = 3'd4,
      CSR_READ_REG_LIMIT   = 3'd5,
      CSR_WRITE_COIL_LIMIT = 3'd6,
      CSR_WRITE_REG_LIMIT  = 3'd7
   } csr_index_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK          = 4'd0,
      ST_SLAVE       = 4'd1,
      ST_FUNC        = 4'd2,
      ST_ADDR        = 4'd3,
      ST_CNT_RD_COIL = 4'd4,
      ST_CNT_RD_REG  = 4'd5,
      ST_CNT_WR_COIL = 4'd6,
      ST_CNT_WR_REG  = 4'd7,
      ST_OVERFLOW    = 4'd8,
      ST_LENGTH      = 4'd9,
      ST_STRAY       = 4'd10
   } status_type;

   typedef enum logic [1:0] {
      CMD_ERR   = 2'd0,
      CMD_READ  = 2'd1,
      CMD_WRITE = 2'd2,
      CMD_DATA  = 2'd3
   } cmd_kind_type;

   // one classified request handed from front to back
   typedef struct packed {
      cmd_kind_type         kind;
      status_type           status;
      logic [BYTE_W-1:0]    slave;
      logic [BYTE_W-1:0]    func;
      logic [ADDR_W-1:0]    addr;
      logic [COUNT_W-1:0]   count;
      logic [BYTE_W-1:0]    data;
      logic                 ends_frame;
   } cmd_type;

   typedef struct packed {
      logic [BYTE_W-1:0] frame_byte;
      logic              byte_valid;
      status_type        status;
      logic              last;
   } rsp_type;

endpackage

>>> design/mbrtu_queue.sv
`timescale 1ns / 1ps

module mbrtu_queue #(
   parameter int unsigned DEPTH = 4,
   parameter int unsigned WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] rd_data
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full    = (cnt_ff == FULL_CNT);
   assign empty   = (cnt_ff == '0);
   assign rd_data = slot_ff[rd_ptr_ff];

   // a full queue still takes a push in the cycle its head leaves
   assign do_pop  = pop && !empty;
   assign do_push = push && (!full || do_pop);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

   a_cnt_bounded: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= FULL_CNT)
      else $error("queue occupancy beyond depth");

endmodule

>>> design/mbrtu_front.sv
`timescale 1ns / 1ps

module mbrtu_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [mbrtu_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [mbrtu_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                                req_push,
   input  logic                                req_opcode,
   input  logic [mbrtu_pkg::BYTE_W-1:0]        req_slave_id,
   input  logic [mbrtu_pkg::BYTE_W-1:0]        req_func_code,
   input  logic [mbrtu_pkg::ADDR_W-1:0]        req_start_addr,
   input  logic [mbrtu_pkg::COUNT_W-1:0]       req_item_count,
   input  logic [mbrtu_pkg::BYTE_W-1:0]        req_payload_len,
   input  logic [mbrtu_pkg::BYTE_W-1:0]        req_payload_byte,
   input  logic                                cmd_full,
   output logic                                cmd_push,
   output mbrtu_pkg::cmd_type                  cmd_wr
);

   import mbrtu_pkg::*;

   logic [BYTE_W-1:0]  slave_min_ff, slave_max_ff;
   logic [ADDR_W-1:0]  addr_lowest_ff, addr_highest_ff;
   logic [COUNT_W-1:0] read_coil_limit_ff, read_reg_limit_ff;
   logic [COUNT_W-1:0] write_coil_limit_ff, write_reg_limit_ff;

   logic               in_payload_ff, in_payload_in;
   logic [BYTE_W-1:0]  bytes_left_ff, bytes_left_in;

   logic               accept;
   logic               func_ok, is_coil_write, is_reg_write;
   logic [COUNT_W-1:0] limit;
   status_type         cnt_status, hdr_status;
   logic [ADDR_W:0]    addr_end, reg_bytes, coil_bytes;

   assign accept   = req_push && !cmd_full;
   assign cmd_push = accept;

   // function decode: count limit and its error code
   always_comb begin
      func_ok       = 1'b1;
      is_coil_write = 1'b0;
      is_reg_write  = 1'b0;
      limit         = read_coil_limit_ff;
      cnt_status    = ST_CNT_RD_COIL;
      unique case (req_func_code)
         FC_READ_COILS: begin
            limit      = read_coil_limit_ff;
            cnt_status = ST_CNT_RD_COIL;
         end
         FC_READ_REGS: begin
            limit      = read_reg_limit_ff;
            cnt_status = ST_CNT_RD_REG;
         end
         FC_WRITE_COILS: begin
            limit         = write_coil_limit_ff;
            cnt_status    = ST_CNT_WR_COIL;
            is_coil_write = 1'b1;
         end
         FC_WRITE_REGS: begin
            limit        = write_reg_limit_ff;
            cnt_status   = ST_CNT_WR_REG;
            is_reg_write = 1'b1;
         end
         default: begin
            func_ok = 1'b0;
         end
      endcase
   end

   // header checks, first failure wins
   always_comb begin
      addr_end   = {1'b0, req_start_addr} + {1'b0, req_item_count};
      reg_bytes  = {req_item_count, 1'b0};
      coil_bytes = ({1'b0, req_item_count} + (ADDR_W + 1)'(7)) >> 3;
      if (req_slave_id < slave_min_ff || req_slave_id > slave_max_ff) begin
         hdr_status = ST_SLAVE;
      end else if (!func_ok) begin
         hdr_status = ST_FUNC;
      end else if (req_start_addr < addr_lowest_ff || req_start_addr > addr_highest_ff) begin
         hdr_status = ST_ADDR;
      end else if (req_item_count == '0 || req_item_count > limit) begin
         hdr_status = cnt_status;
      end else if (addr_end > {1'b0, addr_highest_ff}) begin
         hdr_status = ST_OVERFLOW;
      end else if (is_coil_write && coil_bytes != (ADDR_W + 1)'(req_payload_len)) begin
         hdr_status = ST_LENGTH;
      end else if (is_reg_write && reg_bytes != (ADDR_W + 1)'(req_payload_len)) begin
         hdr_status = ST_LENGTH;
      end else begin
         hdr_status = ST_OK;
      end
   end

   // classify the request and track the open write frame
   always_comb begin
      cmd_wr        = '0;
      cmd_wr.kind   = CMD_ERR;
      cmd_wr.status = ST_OK;
      cmd_wr.slave  = req_slave_id;
      cmd_wr.func   = req_func_code;
      cmd_wr.addr   = req_start_addr;
      cmd_wr.count  = req_item_count;
      in_payload_in = in_payload_ff;
      bytes_left_in = bytes_left_ff;
      if (req_opcode == OP_HEADER) begin
         cmd_wr.data   = req_payload_len;
         in_payload_in = 1'b0;
         bytes_left_in = '0;
         if (hdr_status != ST_OK) begin
            cmd_wr.status = hdr_status;
         end else if (is_coil_write || is_reg_write) begin
            cmd_wr.kind   = CMD_WRITE;
            in_payload_in = 1'b1;
            bytes_left_in = req_payload_len;
         end else begin
            cmd_wr.kind = CMD_READ;
         end
      end else begin
         cmd_wr.data = req_payload_byte;
         if (!in_payload_ff) begin
            cmd_wr.status = ST_STRAY;
         end else begin
            cmd_wr.kind       = CMD_DATA;
            cmd_wr.ends_frame = (bytes_left_ff == 8'd1);
            bytes_left_in     = bytes_left_ff - 1'b1;
            in_payload_in     = (bytes_left_ff != 8'd1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_payload_ff <= 1'b0;
         bytes_left_ff <= '0;
      end else if (accept) begin
         in_payload_ff <= in_payload_in;
         bytes_left_ff <= bytes_left_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_min_ff        <= SLAVE_MIN_RST;
         slave_max_ff        <= SLAVE_MAX_RST;
         addr_lowest_ff      <= ADDR_LOWEST_RST;
         addr_highest_ff     <= ADDR_HIGHEST_RST;
         read_coil_limit_ff  <= READ_COIL_LIMIT_RST;
         read_reg_limit_ff   <= READ_REG_LIMIT_RST;
         write_coil_limit_ff <= WRITE_COIL_LIMIT_RST;
         write_reg_limit_ff  <= WRITE_REG_LIMIT_RST;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_SLAVE_MIN:        slave_min_ff        <= csr_wdata[BYTE_W-1:0];
            CSR_SLAVE_MAX:        slave_max_ff        <= csr_wdata[BYTE_W-1:0];
            CSR_ADDR_LOWEST:      addr_lowest_ff      <= csr_wdata;
            CSR_ADDR_HIGHEST:     addr_highest_ff     <= csr_wdata;
            CSR_READ_COIL_LIMIT:  read_coil_limit_ff  <= csr_wdata;
            CSR_READ_REG_LIMIT:   read_reg_limit_ff   <= csr_wdata;
            CSR_WRITE_COIL_LIMIT: write_coil_limit_ff <= csr_wdata;
            CSR_WRITE_REG_LIMIT:  write_reg_limit_ff  <= csr_wdata;
         endcase
      end
   end

   a_payload_count: assert property (@(posedge clock) disable iff (reset)
      in_payload_ff == (bytes_left_ff != '0))
      else $error("open write frame and remaining byte count disagree");

endmodule

>>> design/mbrtu_back.sv
`timescale 1ns / 1ps

module mbrtu_back #(
   parameter int unsigned RSP_DEPTH = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           cmd_empty,
   input  mbrtu_pkg::cmd_type             cmd_head,
   output logic                           cmd_pop,
   input  logic                           rsp_pop,
   output logic                           rsp_empty,
   output logic [mbrtu_pkg::BYTE_W-1:0]   rsp_frame_byte,
   output logic                           rsp_byte_valid,
   output logic [mbrtu_pkg::STATUS_W-1:0] rsp_status,
   output logic                           rsp_last
);

   import mbrtu_pkg::*;

   // step numbers inside one request
   localparam logic [STEP_W-1:0] STEP_FIRST      = 3'd0;
   localparam logic [STEP_W-1:0] STEP_TAIL       = 3'd6;
   localparam logic [STEP_W-1:0] STEP_DATA_CRCHI = 3'd1;
   localparam logic [STEP_W-1:0] STEP_DATA_LAST  = 3'd2;

   function automatic logic [CRC_W-1:0] crc_update(input logic [CRC_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] data);
      logic [CRC_W-1:0] acc;
      acc = crc ^ {{(CRC_W - BYTE_W){1'b0}}, data};
      for (int k = 0; k < BYTE_W; k++) begin
         acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
      end
      return acc;
   endfunction

   logic [STEP_W-1:0] step_ff, step_in;
   logic [CRC_W-1:0]  crc_ff, crc_in, crc_base;
   logic [BYTE_W-1:0] hdr_byte;
   logic              emit, finish, feeds_crc, is_crc_lo;
   logic              out_full;
   rsp_type           rsp, out_rsp;

   assign emit    = !cmd_empty && (!out_full || rsp_pop);
   assign cmd_pop = emit && finish;

   always_comb begin
      unique case (step_ff)
         3'd0:    hdr_byte = cmd_head.slave;
         3'd1:    hdr_byte = cmd_head.func;
         3'd2:    hdr_byte = cmd_head.addr[ADDR_W-1:BYTE_W];
         3'd3:    hdr_byte = cmd_head.addr[BYTE_W-1:0];
         3'd4:    hdr_byte = cmd_head.count[COUNT_W-1:BYTE_W];
         default: hdr_byte = cmd_head.count[BYTE_W-1:0];
      endcase
   end

   always_comb begin
      rsp       = '0;
      rsp.status = ST_OK;
      finish    = 1'b0;
      feeds_crc = 1'b0;
      is_crc_lo = 1'b0;
      unique case (cmd_head.kind)
         CMD_ERR: begin
            rsp.status = cmd_head.status;
            rsp.last   = 1'b1;
            finish     = 1'b1;
         end
         CMD_READ: begin
            rsp.byte_valid = 1'b1;
            if (step_ff < STEP_TAIL) begin
               rsp.frame_byte = hdr_byte;
               feeds_crc      = 1'b1;
            end else if (step_ff == STEP_TAIL) begin
               rsp.frame_byte = crc_ff[CRC_W-1:BYTE_W];
            end else begin
               rsp.frame_byte = crc_ff[BYTE_W-1:0];
               rsp.last       = 1'b1;
               is_crc_lo      = 1'b1;
               finish         = 1'b1;
            end
         end
         CMD_WRITE: begin
            rsp.byte_valid = 1'b1;
            feeds_crc      = 1'b1;
            if (step_ff < STEP_TAIL) begin
               rsp.frame_byte = hdr_byte;
            end else begin
               rsp.frame_byte = cmd_head.data;
               rsp.last       = 1'b1;
               finish         = 1'b1;
            end
         end
         CMD_DATA: begin
            rsp.byte_valid = 1'b1;
            if (step_ff == STEP_FIRST) begin
               rsp.frame_byte = cmd_head.data;
               feeds_crc      = 1'b1;
               rsp.last       = !cmd_head.ends_frame;
               finish         = !cmd_head.ends_frame;
            end else if (step_ff == STEP_DATA_CRCHI) begin
               rsp.frame_byte = crc_ff[CRC_W-1:BYTE_W];
            end else begin
               rsp.frame_byte = crc_ff[BYTE_W-1:0];
               rsp.last       = 1'b1;
               is_crc_lo      = 1'b1;
               finish         = 1'b1;
            end
         end
      endcase
   end

   // a new frame starts from the seed, which drops any partial frame
   always_comb begin
      crc_base = crc_ff;
      if (step_ff == STEP_FIRST && (cmd_head.kind == CMD_READ || cmd_head.kind == CMD_WRITE)) begin
         crc_base = CRC_INIT;
      end
      crc_in  = crc_ff;
      step_in = step_ff;
      if (emit) begin
         if (feeds_crc) begin
            crc_in = crc_update(crc_base, rsp.frame_byte);
         end else if (is_crc_lo) begin
            crc_in = CRC_INIT;
         end
         step_in = finish ? STEP_FIRST : step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_FIRST;
         crc_ff  <= CRC_INIT;
      end else begin
         step_ff <= step_in;
         crc_ff  <= crc_in;
      end
   end

   mbrtu_queue #(
      .DEPTH (RSP_DEPTH),
      .WIDTH ($bits(rsp_type))
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (emit),
      .wr_data (rsp),
      .full    (out_full),
      .pop     (rsp_pop),
      .empty   (rsp_empty),
      .rd_data (out_rsp)
   );

   assign rsp_frame_byte = out_rsp.frame_byte;
   assign rsp_byte_valid = out_rsp.byte_valid;
   assign rsp_status     = out_rsp.status;
   assign rsp_last       = out_rsp.last;

   a_step_needs_cmd: assert property (@(posedge clock) disable iff (reset)
      (step_ff != STEP_FIRST) |-> (!cmd_empty && cmd_head.kind != CMD_ERR &&
         (cmd_head.kind == CMD_READ || step_ff <= STEP_TAIL) &&
         (cmd_head.kind != CMD_DATA || step_ff <= STEP_DATA_LAST)))
      else $error("sequencer step out of range for the request at the head");

   a_crc_reseed: assert property (@(posedge clock) disable iff (reset)
      (emit && is_crc_lo) |=> (crc_ff == CRC_INIT && step_ff == STEP_FIRST))
      else $error("crc not reseeded after closing a frame");

endmodule

>>> design/modbus_rtu_request_framer_unit.sv
`timescale 1ns / 1ps

// channel   ports                                   transfer
// request   req_push / req_full, req_* fields       push high and full low
// result    rsp_empty / rsp_pop, rsp_* fields       pop high and empty low
// config    csr_we, csr_index, csr_wdata            every edge with csr_we high
//
// one request enters per cycle while the request queue has room
// results leave at one per cycle from the frame sequencer: a read header yields
// its fields and the crc, a write header its fields and the length, a payload
// byte itself (and the crc if it ends the frame), an error or stray byte a status
// the sequencer stalls only when the result queue is full and not popped;
// the request side stalls only when CMD_DEPTH requests wait behind it
// reset is synchronous; it empties both queues and restores the register defaults

module modbus_rtu_request_framer_unit #(
   parameter int unsigned CMD_DEPTH = 4,
   parameter int unsigned RSP_DEPTH = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_push,
   output logic                              req_full,
   input  logic                              req_opcode,
   input  logic [mbrtu_pkg::BYTE_W-1:0]      req_slave_id,
   input  logic [mbrtu_pkg::BYTE_W-1:0]      req_func_code,
   input  logic [mbrtu_pkg::ADDR_W-1:0]      req_start_addr,
   input  logic [mbrtu_pkg::COUNT_W-1:0]     req_item_count,
   input  logic [mbrtu_pkg::BYTE_W-1:0]      req_payload_len,
   input  logic [mbrtu_pkg::BYTE_W-1:0]      req_payload_byte,
   // result channel
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic [mbrtu_pkg::BYTE_W-1:0]      rsp_frame_byte,
   output logic                              rsp_byte_valid,
   output logic [mbrtu_pkg::STATUS_W-1:0]    rsp_status,
   output logic                              rsp_last,
   // register writes
   input  logic                              csr_we,
   input  logic [mbrtu_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mbrtu_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   import mbrtu_pkg::*;

   // classified requests between front and back
   logic    cmd_push, cmd_full, cmd_empty, cmd_pop;
   cmd_type cmd_wr, cmd_head;

   // front: register file, header checks, open write frame tracking
   mbrtu_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_push         (req_push),
      .req_opcode       (req_opcode),
      .req_slave_id     (req_slave_id),
      .req_func_code    (req_func_code),
      .req_start_addr   (req_start_addr),
      .req_item_count   (req_item_count),
      .req_payload_len  (req_payload_len),
      .req_payload_byte (req_payload_byte),
      .cmd_full         (cmd_full),
      .cmd_push         (cmd_push),
      .cmd_wr           (cmd_wr)
   );

   assign req_full = cmd_full;

   // decouples classification from byte sequencing
   mbrtu_queue #(
      .DEPTH (CMD_DEPTH),
      .WIDTH ($bits(cmd_type))
   ) u_cmd_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_push),
      .wr_data (cmd_wr),
      .full    (cmd_full),
      .pop     (cmd_pop),
      .empty   (cmd_empty),
      .rd_data (cmd_head)
   );

   // back: byte sequencer with crc and result queue
   mbrtu_back #(
      .RSP_DEPTH (RSP_DEPTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_empty      (cmd_empty),
      .cmd_head       (cmd_head),
      .cmd_pop        (cmd_pop),
      .rsp_pop        (rsp_pop),
      .rsp_empty      (rsp_empty),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_status     (rsp_status),
      .rsp_last       (rsp_last)
   );

endmodule
